FILE: rtl/tcts_pkg.sv
// ============================================================================
// Tone sequencer package
// Shared sizes, command codes and record types of the two-channel tone
// sequencer: step store and sequence table layouts and per-channel state.
// ============================================================================
`default_nettype none

package tcts_pkg;

   // Step store depth; a power of two so that a step address wraps by masking.
   localparam int STEP_DEPTH  = 256;
   // Number of sounds held in the sequence table.
   localparam int SOUND_COUNT = 8;

   localparam int STEP_AW = $clog2(STEP_DEPTH);
   localparam int SND_AW  = (SOUND_COUNT > 1) ? $clog2(SOUND_COUNT) : 1;
   // Width that holds base plus index before it wraps into the step store.
   localparam int SUM_W   = (STEP_AW > 9) ? STEP_AW : 9;

   localparam logic [2:0] CMD_TICK      = 3'd0;
   localparam logic [2:0] CMD_PLAY      = 3'd1;
   localparam logic [2:0] CMD_STOP      = 3'd2;
   localparam logic [2:0] CMD_LOAD_STEP = 3'd3;
   localparam logic [2:0] CMD_LOAD_SEQ  = 3'd4;

   localparam logic [8:0] MAX_COUNT = 9'd256;

   typedef struct packed {
      logic [7:0] base;
      logic [8:0] count;
      logic       looping;
   } seq_entry_type;

   localparam int SEQ_W = $bits(seq_entry_type);

   localparam seq_entry_type SEQ_RESET = '{base: 8'd0, count: 9'd1, looping: 1'b0};

   typedef struct packed {
      logic [15:0] note;
      logic [15:0] duration;
   } step_entry_type;

   localparam int STEP_W = $bits(step_entry_type);

   typedef struct packed {
      logic [SND_AW-1:0] sound;
      logic [7:0]        index;
      logic [31:0]       deadline;
      logic              playing;
      logic [15:0]       note;
   } chan_state_type;

   // What one channel does with the word in flight.
   typedef struct packed {
      logic       start;   // load a step: note, deadline and index
      logic       stop;    // clear the channel
      logic       play;    // a new sound begins, take the sound number
      logic [7:0] index;   // step index within the sound
   } chan_plan_type;

endpackage

`default_nettype wire

FILE: rtl/two_channel_tone_sequencer_unit.sv
// ============================================================================
// Two-channel tone sequencer
// Plays note sequences on a background and an effect channel from a step
// store and a sequence table, advanced by a millisecond tick word.
// ============================================================================
//
//   Channel   Direction  Handshake          Carries
//   req_*     in         valid / stall      one command word
//   rsp_*     out        valid / stall      tones and active flags, one per word
//
// The sequence table is read at the accepting edge, the step store from the
// first stage, and the channel state is updated as the second stage commits,
// which may also accept the next word: the dependent reads hold off a new word
// until then. After reset a clearing pass over every step store address fills
// both memories with reset contents while req_stall stays high. A stalled
// result holds in the output register, the word behind it in the last stage.
//
`default_nettype none

module two_channel_tone_sequencer_unit
   import tcts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic        req_channel,
   input  logic [3:0]  req_sound_id,
   input  logic [7:0]  req_address,
   input  logic [15:0] req_note,
   input  logic [15:0] req_delay,
   input  logic [8:0]  req_step_count,
   input  logic        req_loop_flag,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_background_tone,
   output logic [15:0] rsp_effect_tone,
   output logic        rsp_background_active,
   output logic        rsp_effect_active
);

   // One accepted command word as it moves through the two stages.
   typedef struct packed {
      logic [2:0]  command;
      logic        channel;
      logic [3:0]  sound_id;
      logic [7:0]  address;
      logic [15:0] note;
      logic [15:0] duration;
      logic [8:0]  step_count;
      logic        loop_flag;
   } req_word_type;

   req_word_type req_word;

   // Clearing pass.
   logic               clearing_ff;
   logic [STEP_AW-1:0] clear_cnt_ff;

   // Channel state and time base. Index 0 is background, 1 is effect.
   chan_state_type chan_ff [2];
   chan_state_type chan_in [2];
   logic [31:0]    time_now_ff;
   logic [31:0]    time_now_in;
   logic [31:0]    time_next;

   // First stage: sequence table data arrives.
   logic          s1_valid_ff;
   req_word_type  s1_word_ff;
   logic          seq_hit_ff [2];
   logic          seq_hit_in [2];
   seq_entry_type seq_fwd_ff;
   seq_entry_type seq_q [2];
   seq_entry_type seq_eff [2];
   logic          s1_id_ok;
   logic [31:0]   s1_time_base;
   chan_plan_type s1_plan [2];
   logic [STEP_AW-1:0] step_raddr [2];

   // Second stage: step store data arrives and the word commits.
   logic           s2_valid_ff;
   req_word_type   s2_word_ff;
   chan_plan_type  s2_plan_ff [2];
   logic [31:0]    s2_time_base_ff;
   logic           s2_id_ok;
   step_entry_type step_q [2];
   logic           commit;

   // Memory ports.
   logic               accept;
   logic               seq_we;
   logic [SND_AW-1:0]  seq_waddr;
   seq_entry_type      seq_wdata;
   logic [SND_AW-1:0]  seq_raddr [2];
   logic               step_we;
   logic [STEP_AW-1:0] step_waddr;
   step_entry_type     step_wdata;

   // Result register.
   logic        rsp_valid_ff;
   logic [15:0] rsp_bg_tone_ff;
   logic [15:0] rsp_fx_tone_ff;
   logic        rsp_bg_active_ff;
   logic        rsp_fx_active_ff;

   assign req_word = '{command: req_command, channel: req_channel,
                       sound_id: req_sound_id, address: req_address,
                       note: req_note, duration: req_delay,
                       step_count: req_step_count, loop_flag: req_loop_flag};

   // A word is committed once the result register is free or being emptied.
   // A new word enters when the first stage is empty and the second stage is
   // empty or committing, so the state it reads is the state after the word
   // ahead of it.
   assign commit    = s2_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = clearing_ff || s1_valid_ff || (s2_valid_ff && !commit);
   assign accept    = req_valid && !req_stall;

   // ------------------------------------------------------------------
   // Memories
   // ------------------------------------------------------------------

   // The sequence table address of each channel: the requested sound for a
   // play word aimed at it, otherwise the sound it holds after this edge.
   always_comb begin
      for (int c = 0; c < 2; c++) begin
         if ((req_command == CMD_PLAY) && (req_channel == c[0])) begin
            seq_raddr[c] = SND_AW'(req_sound_id);
         end else begin
            seq_raddr[c] = chan_in[c].sound;
         end
         // A table write at the same edge as the read is forwarded.
         seq_hit_in[c] = seq_we && (seq_waddr == seq_raddr[c]);
      end
   end

   assign s2_id_ok = ({1'b0, s2_word_ff.sound_id} < 5'(SOUND_COUNT));

   always_comb begin
      if (clearing_ff) begin
         seq_we    = (32'(clear_cnt_ff) < SOUND_COUNT);
         seq_waddr = clear_cnt_ff[SND_AW-1:0];
         seq_wdata = SEQ_RESET;
      end else begin
         seq_we    = commit && (s2_word_ff.command == CMD_LOAD_SEQ) && s2_id_ok;
         seq_waddr = SND_AW'(s2_word_ff.sound_id);
         seq_wdata = '{base: s2_word_ff.address,
                       count: (s2_word_ff.step_count > MAX_COUNT) ? MAX_COUNT
                                                                  : s2_word_ff.step_count,
                       looping: s2_word_ff.loop_flag};
      end
   end

   always_comb begin
      if (clearing_ff) begin
         step_we    = 1'b1;
         step_waddr = clear_cnt_ff;
         step_wdata = '0;
      end else begin
         step_we    = commit && (s2_word_ff.command == CMD_LOAD_STEP)
                      && (32'(s2_word_ff.address) < STEP_DEPTH);
         step_waddr = STEP_AW'(s2_word_ff.address);
         step_wdata = '{note: s2_word_ff.note, duration: s2_word_ff.duration};
      end
   end

   tcts_ram #(
      .WIDTH (SEQ_W),
      .DEPTH (SOUND_COUNT)
   ) u_seq_ram (
      .clock     (clock),
      .wr_en     (seq_we),
      .wr_addr   (seq_waddr),
      .wr_data   (seq_wdata),
      .rd_en_a   (accept),
      .rd_addr_a (seq_raddr[0]),
      .rd_data_a (seq_q[0]),
      .rd_en_b   (accept),
      .rd_addr_b (seq_raddr[1]),
      .rd_data_b (seq_q[1])
   );

   tcts_ram #(
      .WIDTH (STEP_W),
      .DEPTH (STEP_DEPTH)
   ) u_step_ram (
      .clock     (clock),
      .wr_en     (step_we),
      .wr_addr   (step_waddr),
      .wr_data   (step_wdata),
      .rd_en_a   (s1_valid_ff),
      .rd_addr_a (step_raddr[0]),
      .rd_data_a (step_q[0]),
      .rd_en_b   (s1_valid_ff),
      .rd_addr_b (step_raddr[1]),
      .rd_data_b (step_q[1])
   );

   // ------------------------------------------------------------------
   // First stage: plan each channel and address the step store
   // ------------------------------------------------------------------

   assign time_next    = time_now_ff + 32'd1;
   assign s1_id_ok     = ({1'b0, s1_word_ff.sound_id} < 5'(SOUND_COUNT));
   // A tick works against the advanced time; a play starts at the present time.
   assign s1_time_base = (s1_word_ff.command == CMD_TICK) ? time_next : time_now_ff;

   always_comb begin
      for (int c = 0; c < 2; c++) begin
         seq_eff[c] = seq_hit_ff[c] ? seq_fwd_ff : seq_q[c];
      end
   end

   tcts_chan_plan u_plan_bg (
      .command   (s1_word_ff.command),
      .target    (s1_word_ff.channel == 1'b0),
      .id_ok     (s1_id_ok),
      .time_next (time_next),
      .state     (chan_ff[0]),
      .seq       (seq_eff[0]),
      .plan      (s1_plan[0]),
      .step_addr (step_raddr[0])
   );

   tcts_chan_plan u_plan_fx (
      .command   (s1_word_ff.command),
      .target    (s1_word_ff.channel == 1'b1),
      .id_ok     (s1_id_ok),
      .time_next (time_next),
      .state     (chan_ff[1]),
      .seq       (seq_eff[1]),
      .plan      (s1_plan[1]),
      .step_addr (step_raddr[1])
   );

   // ------------------------------------------------------------------
   // Second stage: commit the channel updates
   // ------------------------------------------------------------------

   always_comb begin
      for (int c = 0; c < 2; c++) begin
         chan_in[c] = chan_ff[c];
         if (commit) begin
            if (s2_plan_ff[c].stop) begin
               chan_in[c] = '0;
            end else if (s2_plan_ff[c].start) begin
               chan_in[c].note     = step_q[c].note;
               chan_in[c].deadline = s2_time_base_ff + {16'd0, step_q[c].duration};
               chan_in[c].index    = s2_plan_ff[c].index;
               chan_in[c].playing  = 1'b1;
               if (s2_plan_ff[c].play) begin
                  chan_in[c].sound = SND_AW'(s2_word_ff.sound_id);
               end
            end
         end
      end
   end

   assign time_now_in = (commit && (s2_word_ff.command == CMD_TICK)) ? s2_time_base_ff
                                                                      : time_now_ff;

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_cnt_ff <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         time_now_ff  <= '0;
         chan_ff[0]   <= '0;
         chan_ff[1]   <= '0;
      end else begin
         if (clearing_ff) begin
            clear_cnt_ff <= clear_cnt_ff + STEP_AW'(1);
            if (clear_cnt_ff == STEP_AW'(STEP_DEPTH - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
         s1_valid_ff <= accept;
         // The first stage always moves on: it only fills behind an empty
         // or committing second stage.
         if (s1_valid_ff) begin
            s2_valid_ff <= 1'b1;
         end else if (commit) begin
            s2_valid_ff <= 1'b0;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         time_now_ff <= time_now_in;
         chan_ff[0]  <= chan_in[0];
         chan_ff[1]  <= chan_in[1];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_word_ff    <= req_word;
         seq_hit_ff[0] <= seq_hit_in[0];
         seq_hit_ff[1] <= seq_hit_in[1];
         seq_fwd_ff    <= seq_wdata;
      end
      if (s1_valid_ff) begin
         s2_word_ff      <= s1_word_ff;
         s2_plan_ff[0]   <= s1_plan[0];
         s2_plan_ff[1]   <= s1_plan[1];
         s2_time_base_ff <= s1_time_base;
      end
      if (commit) begin
         rsp_bg_tone_ff   <= chan_in[0].note;
         rsp_fx_tone_ff   <= chan_in[1].note;
         rsp_bg_active_ff <= chan_in[0].playing;
         rsp_fx_active_ff <= chan_in[1].playing;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_background_tone   = rsp_bg_tone_ff;
   assign rsp_effect_tone       = rsp_fx_tone_ff;
   assign rsp_background_active = rsp_bg_active_ff;
   assign rsp_effect_active     = rsp_fx_active_ff;

endmodule

`default_nettype wire

FILE: rtl/tcts_ram.sv
// ============================================================================
// Generic RAM
// One write port and two read ports with enables; read data is registered
// and holds until the next enabled read. A read at the address being written
// returns the old contents.
// ============================================================================
`default_nettype none

module tcts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en_a,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]                         rd_data_a,
   input  logic                                     rd_en_b,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]                         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en_a) begin
         rd_a_ff <= mem_ff[rd_addr_a];
      end
      if (rd_en_b) begin
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

FILE: rtl/tcts_chan_plan.sv
// ============================================================================
// Channel step planner
// Decides, for one channel, whether the word in flight starts a step, stops
// the channel or leaves it alone, and forms the step store address.
// ============================================================================
`default_nettype none

module tcts_chan_plan
   import tcts_pkg::*;
(
   input  logic [2:0]         command,
   input  logic               target,
   input  logic               id_ok,
   input  logic [31:0]        time_next,
   input  chan_state_type     state,
   input  seq_entry_type      seq,
   output chan_plan_type      plan,
   output logic [STEP_AW-1:0] step_addr
);

   logic [31:0]    diff;
   logic           due;
   logic [8:0]     next_index;
   logic           at_end;
   logic [SUM_W-1:0] addr_sum;

   assign diff       = time_next - state.deadline;
   assign due        = state.playing && !diff[31];
   assign next_index = {1'b0, state.index} + 9'd1;
   assign at_end     = (next_index >= seq.count);

   always_comb begin
      plan = '0;
      case (command)
         CMD_TICK: begin
            if (due) begin
               if (at_end && !seq.looping) begin
                  plan.stop = 1'b1;
               end else begin
                  plan.start = 1'b1;
                  plan.index = at_end ? 8'd0 : next_index[7:0];
               end
            end
         end
         CMD_PLAY: begin
            if (target && id_ok) begin
               plan.start = 1'b1;
               plan.play  = 1'b1;
            end
         end
         CMD_STOP: begin
            plan.stop = target;
         end
         default: begin
            plan = '0;
         end
      endcase
   end

   // The sum wraps modulo the step store depth by keeping its low bits.
   assign addr_sum  = SUM_W'(seq.base) + SUM_W'(plan.index);
   assign step_addr = addr_sum[STEP_AW-1:0];

endmodule

`default_nettype wire

FILE: rtl/tcts_checker.sv
// ============================================================================
// Tone sequencer port checker
// Watches the ports of the tone sequencer and flags behavior that the
// block must never show.
// ============================================================================
`default_nettype none

module tcts_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_background_tone,
   input logic [15:0] rsp_effect_tone,
   input logic        rsp_background_active,
   input logic        rsp_effect_active
);

   // A stalled result word stays and does not change.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_background_tone)
         && $stable(rsp_effect_tone) && $stable(rsp_background_active)
         && $stable(rsp_effect_active))
      else $error("stalled result word changed");

   // Reset empties the result register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   // An accepted word fills the first stage, so the cycle after an accept is stalled.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input word accepted in consecutive cycles");

   // An idle channel is always silent.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_background_active || (rsp_background_tone == 16'd0))
                 && (rsp_effect_active || (rsp_effect_tone == 16'd0)))
      else $error("inactive channel reports a tone");

endmodule

bind two_channel_tone_sequencer_unit tcts_checker u_checker (.*);

`default_nettype wire
